// ----- hw/rtl/tlik_pkg.sv -----
// Shared types, constants and constant tables for the two-link arm IK block.
// Holds the Q60 arctangent table, the rounded pi constants and the angle conversion.
// No dependencies.
package tlik_pkg;

   localparam int ANGLE_FRAC_BITS   = 20;
   localparam int CORDIC_ITERATIONS = 24;
   localparam int ATAN_DEPTH        = 32;
   localparam int ITER_W            = $clog2(ATAN_DEPTH);
   localparam int OPND_W            = 48;
   localparam int ANG_W             = 36;
   localparam int D_FRAC            = 30;
   localparam int DEN_W             = 33;
   localparam int SQ_W              = 2 * D_FRAC + 1;

   localparam logic REG_FIRST_LINK  = 1'b0;
   localparam logic REG_SECOND_LINK = 1'b1;

   localparam logic [63:0] Q60_ONE = 64'd1 << 60;

   typedef logic signed [63:0] q60_type;
   typedef logic [63:0] atan_tab_type [ATAN_DEPTH];

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

   // atan(2^-sh) in Q60 from its power series.
   function automatic logic [63:0] atan_pow2(input int sh);
      logic [63:0] t;
      logic [63:0] s;
      int          k;
      t = Q60_ONE >> sh;
      s = 64'd0;
      k = 0;
      while (t != 64'd0) begin
         if (k[0] == 1'b0) begin
            s = s + t / 64'(2 * k + 1);
         end else begin
            s = s - t / 64'(2 * k + 1);
         end
         t = t >> (2 * sh);
         k = k + 1;
      end
      return s;
   endfunction

   // pi/4 in Q60 by the Machin formula.
   function automatic logic [63:0] atan_first();
      logic [63:0] t;
      logic [63:0] s5;
      logic [63:0] s239;
      int          k;
      t  = Q60_ONE / 5;
      s5 = 64'd0;
      k  = 0;
      while (t != 64'd0) begin
         if (k[0] == 1'b0) begin
            s5 = s5 + t / 64'(2 * k + 1);
         end else begin
            s5 = s5 - t / 64'(2 * k + 1);
         end
         t = t / 25;
         k = k + 1;
      end
      t    = Q60_ONE / 239;
      s239 = 64'd0;
      k    = 0;
      while (t != 64'd0) begin
         if (k[0] == 1'b0) begin
            s239 = s239 + t / 64'(2 * k + 1);
         end else begin
            s239 = s239 - t / 64'(2 * k + 1);
         end
         t = t / 57121;
         k = k + 1;
      end
      return (s5 << 2) - s239;
   endfunction

   function automatic atan_tab_type build_atan();
      atan_tab_type tab;
      tab[0] = atan_first();
      for (int i = 1; i < ATAN_DEPTH; i++) begin
         tab[i] = atan_pow2(i);
      end
      return tab;
   endfunction

   localparam atan_tab_type ATAN_TAB = build_atan();

   localparam q60_type HALF_PI_Q60 = q60_type'(ATAN_TAB[0] << 1);
   localparam q60_type PI_Q60      = q60_type'(ATAN_TAB[0] << 2);
   localparam q60_type TWO_PI_Q60  = q60_type'(ATAN_TAB[0] << 3);

   // Q60 radians to the output angle format, rounded half up.
   function automatic logic signed [ANG_W-1:0] to_angle(input q60_type v);
      q60_type r;
      r = v + (64'sd1 <<< (59 - ANGLE_FRAC_BITS));
      r = r >>> (60 - ANGLE_FRAC_BITS);
      return r[ANG_W-1:0];
   endfunction

   localparam logic signed [ANG_W-1:0] PI_ANGLE     = to_angle(PI_Q60);
   localparam logic signed [ANG_W-1:0] TWO_PI_ANGLE = to_angle(TWO_PI_Q60);

endpackage

// ----- hw/rtl/two_link_arm_inverse_kinematics_top.sv -----
// Two-link planar arm inverse kinematics: target (x, y) and tool yaw in, three joint
// angles, the elbow branch and an out-of-reach flag out, one result word per input word.
// Depends on tlik_pkg, tlik_divider, tlik_sqrt and tlik_cordic.
//
// While a word is worked on, req_stall is high. The work is a 30-step divider for the
// elbow cosine, which is skipped when the cosine clamps, and a 31-step square root. Then
// come three passes through one CORDIC unit: normalization plus 24 rotation steps each,
// or none of these when both operands are zero. A shared 32x32 multiplier and the
// unwrapping sit in between. The next word is taken as soon as the result sits in the
// output register, even if it is still waiting. Link lengths are to be written over the
// APB port (first link at 0x0, second at 0x4) only while the block is idle; the block
// itself does not enforce this. Angles are signed Q11.20 radians; the shoulder and
// elbow angles are unwrapped toward the previous result, which reset clears to zero.
module two_link_arm_inverse_kinematics_top
   import tlik_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [17:0] req_target_x,
   input  logic signed [17:0] req_target_y,
   input  logic signed [31:0] req_tool_yaw,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_shoulder_angle,
   output logic signed [31:0] rsp_elbow_angle,
   output logic signed [31:0] rsp_wrist_angle,
   output logic               rsp_elbow_positive,
   output logic               rsp_unreachable,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   typedef enum logic [4:0] {
      S_IDLE, S_MUL_XX, S_MUL_YY, S_MUL_L1, S_MUL_L2, S_MUL_DEN, S_DIV_GO, S_DIV_WAIT,
      S_MUL_QQ, S_SQRT_GO, S_SQRT_WAIT, S_CE_GO, S_CE_WAIT, S_MUL_SN, S_MUL_LD,
      S_CB_GO, S_CB_WAIT, S_CA_GO, S_CA_WAIT, S_UNW_SH, S_FIN_EL, S_UNW_EL, S_FIN_WR
   } state_type;

   localparam int NUM_W = 37;
   localparam logic [D_FRAC:0] D_ONE = (D_FRAC + 1)'(1) << D_FRAC;

   state_type                 state_ff;
   logic [15:0]               l1_ff;
   logic [15:0]               l2_ff;
   logic signed [17:0]        x_ff;
   logic signed [17:0]        y_ff;
   logic signed [31:0]        yaw_ff;
   logic                      positive_ff;
   logic signed [NUM_W-1:0]   num_ff;
   logic [DEN_W-1:0]          den_ff;
   logic [D_FRAC:0]           q_ff;
   logic                      unreach_ff;
   logic [SQ_W-1:0]           sqv_ff;
   logic [D_FRAC:0]           s_ff;
   logic signed [31:0]        d_ff;
   q60_type                   e60_ff;
   q60_type                   b60_ff;
   logic signed [OPND_W-1:0]  p1_ff;
   logic signed [OPND_W-1:0]  cx_ff;
   logic signed [ANG_W-1:0]   ang_ff;
   logic signed [31:0]        t1_ff;
   logic signed [31:0]        t2_ff;
   logic signed [31:0]        last_sh_ff;
   logic signed [31:0]        last_el_ff;
   logic                      rsp_valid_ff;
   logic signed [31:0]        out_sh_ff;
   logic signed [31:0]        out_el_ff;
   logic signed [31:0]        out_wr_ff;
   logic                      out_pos_ff;
   logic                      out_unr_ff;

   logic signed [31:0]        mul_a;
   logic signed [31:0]        mul_b;
   logic signed [63:0]        mul_p;
   logic [NUM_W-1:0]          anum;
   logic signed [31:0]        sn;
   logic signed [ANG_W-1:0]   last_el_w;
   logic signed [ANG_W-1:0]   wrist_w;
   logic                      out_free;

   logic                      div_start;
   unit_stat_type             div_stat;
   logic [D_FRAC-1:0]         div_q;
   logic                      sq_start;
   unit_stat_type             sq_stat;
   logic [D_FRAC:0]           sq_root;
   logic                      cord_start;
   logic signed [OPND_W-1:0]  cord_y;
   logic signed [OPND_W-1:0]  cord_x;
   unit_stat_type             cord_stat;
   q60_type                   cord_angle;

   function automatic logic signed [31:0] sat32(input logic signed [ANG_W-1:0] v);
      logic signed [ANG_W-1:0] hi;
      logic signed [ANG_W-1:0] lo;
      hi = {{(ANG_W - 32){1'b0}}, 32'h7fff_ffff};
      lo = {{(ANG_W - 32){1'b1}}, 32'h8000_0000};
      if (v > hi) begin
         return hi[31:0];
      end else if (v < lo) begin
         return lo[31:0];
      end
      return v[31:0];
   endfunction

   // Move the angle by a full turn when that copy lies strictly nearest the last one.
   function automatic logic signed [31:0] unwrap_sat(input logic signed [ANG_W-1:0] t,
                                                     input logic signed [31:0] last);
      logic signed [ANG_W-1:0] lw;
      logic signed [ANG_W-1:0] tu;
      logic signed [ANG_W-1:0] td;
      logic signed [ANG_W-1:0] du;
      logic signed [ANG_W-1:0] dd;
      logic signed [ANG_W-1:0] ds;
      logic signed [ANG_W-1:0] r;
      lw = {{(ANG_W - 32){last[31]}}, last};
      tu = t + TWO_PI_ANGLE;
      td = t - TWO_PI_ANGLE;
      du = (tu > lw) ? tu - lw : lw - tu;
      dd = (td > lw) ? td - lw : lw - td;
      ds = (t > lw) ? t - lw : lw - t;
      if (du < dd && du < ds) begin
         r = tu;
      end else if (dd < du && dd < ds) begin
         r = td;
      end else begin
         r = t;
      end
      return sat32(r);
   endfunction

   // Shared multiplier; operands are chosen by the sequencer state.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_MUL_XX: begin
            mul_a = {{14{x_ff[17]}}, x_ff};
            mul_b = {{14{x_ff[17]}}, x_ff};
         end
         S_MUL_YY: begin
            mul_a = {{14{y_ff[17]}}, y_ff};
            mul_b = {{14{y_ff[17]}}, y_ff};
         end
         S_MUL_L1: begin
            mul_a = {16'd0, l1_ff};
            mul_b = {16'd0, l1_ff};
         end
         S_MUL_L2: begin
            mul_a = {16'd0, l2_ff};
            mul_b = {16'd0, l2_ff};
         end
         S_MUL_DEN: begin
            mul_a = {16'd0, l1_ff};
            mul_b = {16'd0, l2_ff};
         end
         S_MUL_QQ: begin
            mul_a = {1'b0, q_ff};
            mul_b = {1'b0, q_ff};
         end
         S_MUL_SN: begin
            mul_a = {16'd0, l2_ff};
            mul_b = sn;
         end
         S_MUL_LD: begin
            mul_a = {16'd0, l2_ff};
            mul_b = d_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   always_comb begin
      cord_y = '0;
      cord_x = '0;
      case (state_ff)
         S_CE_GO: begin
            cord_y = {{(OPND_W - D_FRAC - 1){1'b0}}, s_ff};
            cord_x = {{(OPND_W - 32){d_ff[31]}}, d_ff};
         end
         S_CB_GO: begin
            cord_y = p1_ff;
            cord_x = cx_ff;
         end
         S_CA_GO: begin
            cord_y = {{(OPND_W - 18){x_ff[17]}}, x_ff};
            cord_x = {{(OPND_W - 18){y_ff[17]}}, y_ff};
         end
         default: begin
            cord_y = '0;
            cord_x = '0;
         end
      endcase
   end

   assign anum       = num_ff[NUM_W-1] ? NUM_W'(-num_ff) : NUM_W'(num_ff);
   assign sn         = positive_ff ? $signed({1'b0, s_ff}) : -$signed({1'b0, s_ff});
   assign last_el_w  = {{(ANG_W - 32){last_el_ff[31]}}, last_el_ff};
   assign wrist_w    = {{(ANG_W - 32){yaw_ff[31]}}, yaw_ff}
                     - {{(ANG_W - 32){t1_ff[31]}}, t1_ff}
                     - {{(ANG_W - 32){t2_ff[31]}}, t2_ff};
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign div_start  = (state_ff == S_DIV_GO) && (den_ff != '0)
                       && (anum < {{(NUM_W - DEN_W){1'b0}}, den_ff});
   assign sq_start   = (state_ff == S_SQRT_GO);
   assign cord_start = (state_ff == S_CE_GO) || (state_ff == S_CB_GO)
                       || (state_ff == S_CA_GO);

   tlik_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (anum[DEN_W-1:0]),
      .divisor  (den_ff),
      .stat     (div_stat),
      .quotient (div_q)
   );

   tlik_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (sqv_ff),
      .stat     (sq_stat),
      .root     (sq_root)
   );

   tlik_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cord_start),
      .y_in  (cord_y),
      .x_in  (cord_x),
      .stat  (cord_stat),
      .angle (cord_angle)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         l1_ff        <= 16'd256;
         l2_ff        <= 16'd256;
         last_sh_ff   <= '0;
         last_el_ff   <= '0;
      end else begin
         if (psel && penable && pwrite) begin
            unique case (paddr[2])
               REG_FIRST_LINK:  l1_ff <= pwdata[15:0];
               REG_SECOND_LINK: l2_ff <= pwdata[15:0];
               default:         l1_ff <= l1_ff;
            endcase
         end
         // The final state reloads the output word itself when it drains.
         if (rsp_valid_ff && !rsp_stall && state_ff != S_FIN_WR) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  x_ff        <= req_target_x;
                  y_ff        <= req_target_y;
                  yaw_ff      <= req_tool_yaw;
                  // Positive branch: last elbow in (0, pi) or in (-2pi, -pi).
                  positive_ff <= (last_el_w > 0 && last_el_w < PI_ANGLE)
                                 || (last_el_w > -TWO_PI_ANGLE && last_el_w < -PI_ANGLE);
                  state_ff    <= S_MUL_XX;
               end
            end
            S_MUL_XX: begin
               num_ff   <= mul_p[NUM_W-1:0];
               state_ff <= S_MUL_YY;
            end
            S_MUL_YY: begin
               num_ff   <= num_ff + mul_p[NUM_W-1:0];
               state_ff <= S_MUL_L1;
            end
            S_MUL_L1: begin
               num_ff   <= num_ff - mul_p[NUM_W-1:0];
               state_ff <= S_MUL_L2;
            end
            S_MUL_L2: begin
               num_ff   <= num_ff - mul_p[NUM_W-1:0];
               state_ff <= S_MUL_DEN;
            end
            S_MUL_DEN: begin
               den_ff   <= {mul_p[DEN_W-2:0], 1'b0};
               state_ff <= S_DIV_GO;
            end
            S_DIV_GO: begin
               // Zero links or a cosine at or beyond one clamp to full scale.
               if (den_ff == '0) begin
                  q_ff       <= D_ONE;
                  unreach_ff <= (num_ff != '0);
                  state_ff   <= S_MUL_QQ;
               end else if (anum >= {{(NUM_W - DEN_W){1'b0}}, den_ff}) begin
                  q_ff       <= D_ONE;
                  unreach_ff <= (anum > {{(NUM_W - DEN_W){1'b0}}, den_ff});
                  state_ff   <= S_MUL_QQ;
               end else begin
                  unreach_ff <= 1'b0;
                  state_ff   <= S_DIV_WAIT;
               end
            end
            S_DIV_WAIT: begin
               if (div_stat.done) begin
                  q_ff     <= {1'b0, div_q};
                  state_ff <= S_MUL_QQ;
               end
            end
            S_MUL_QQ: begin
               sqv_ff   <= (SQ_W'(1) << (2 * D_FRAC)) - mul_p[SQ_W-1:0];
               d_ff     <= num_ff[NUM_W-1] ? -$signed({1'b0, q_ff}) : $signed({1'b0, q_ff});
               state_ff <= S_SQRT_GO;
            end
            S_SQRT_GO: begin
               state_ff <= S_SQRT_WAIT;
            end
            S_SQRT_WAIT: begin
               if (sq_stat.done) begin
                  s_ff     <= sq_root;
                  state_ff <= S_CE_GO;
               end
            end
            S_CE_GO: begin
               state_ff <= S_CE_WAIT;
            end
            S_CE_WAIT: begin
               if (cord_stat.done) begin
                  e60_ff   <= positive_ff ? cord_angle : -cord_angle;
                  state_ff <= S_MUL_SN;
               end
            end
            S_MUL_SN: begin
               p1_ff    <= mul_p[OPND_W-1:0];
               state_ff <= S_MUL_LD;
            end
            S_MUL_LD: begin
               cx_ff    <= $signed({{(OPND_W - 16 - D_FRAC){1'b0}}, l1_ff, {D_FRAC{1'b0}}})
                           + mul_p[OPND_W-1:0];
               state_ff <= S_CB_GO;
            end
            S_CB_GO: begin
               state_ff <= S_CB_WAIT;
            end
            S_CB_WAIT: begin
               if (cord_stat.done) begin
                  b60_ff   <= cord_angle;
                  state_ff <= S_CA_GO;
               end
            end
            S_CA_GO: begin
               state_ff <= S_CA_WAIT;
            end
            S_CA_WAIT: begin
               if (cord_stat.done) begin
                  ang_ff   <= to_angle(cord_angle - b60_ff);
                  state_ff <= S_UNW_SH;
               end
            end
            S_UNW_SH: begin
               t1_ff    <= unwrap_sat(ang_ff, last_sh_ff);
               state_ff <= S_FIN_EL;
            end
            S_FIN_EL: begin
               ang_ff   <= to_angle(e60_ff);
               state_ff <= S_UNW_EL;
            end
            S_UNW_EL: begin
               t2_ff    <= unwrap_sat(ang_ff, last_el_ff);
               state_ff <= S_FIN_WR;
            end
            S_FIN_WR: begin
               if (out_free) begin
                  out_sh_ff    <= t1_ff;
                  out_el_ff    <= t2_ff;
                  out_wr_ff    <= sat32(wrist_w);
                  out_pos_ff   <= positive_ff;
                  out_unr_ff   <= unreach_ff;
                  last_sh_ff   <= t1_ff;
                  last_el_ff   <= t2_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall          = (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_shoulder_angle = out_sh_ff;
   assign rsp_elbow_angle    = out_el_ff;
   assign rsp_wrist_angle    = out_wr_ff;
   assign rsp_elbow_positive = out_pos_ff;
   assign rsp_unreachable    = out_unr_ff;
   assign pready             = 1'b1;
   assign prdata             = (paddr[2] == REG_SECOND_LINK) ? {16'd0, l2_ff}
                                                             : {16'd0, l1_ff};

`ifndef SYNTH
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == S_MUL_XX)
      else $error("accepted word did not start the sequencer");

   a_result_from_final: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FIN_WR))
      else $error("result loaded outside the final state");

   a_cordic_free: assert property (@(posedge clock) disable iff (reset)
      cord_start |-> !cord_stat.busy)
      else $error("CORDIC started while busy");

   a_div_free: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy && !sq_stat.busy)
      else $error("divider started while a unit was busy");
`endif

endmodule

// ----- hw/rtl/tlik_divider.sv -----
// Restoring divider that forms the elbow cosine fraction, one quotient bit per cycle.
// Depends on tlik_pkg.
module tlik_divider
   import tlik_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DEN_W-1:0]   dividend,
   input  logic [DEN_W-1:0]   divisor,
   output unit_stat_type      stat,
   output logic [D_FRAC-1:0]  quotient
);

   localparam int CNT_W = $clog2(D_FRAC);

   logic               busy_ff;
   logic               done_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [DEN_W:0]     rem_ff;
   logic [DEN_W-1:0]   den_ff;
   logic [D_FRAC-1:0]  quo_ff;
   logic [DEN_W:0]     rem_dbl;

   assign rem_dbl = {rem_ff[DEN_W-1:0], 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= {1'b0, dividend};
            den_ff  <= divisor;
            quo_ff  <= '0;
         end else if (busy_ff) begin
            if (rem_dbl >= {1'b0, den_ff}) begin
               rem_ff <= rem_dbl - {1'b0, den_ff};
               quo_ff <= {quo_ff[D_FRAC-2:0], 1'b1};
            end else begin
               rem_ff <= rem_dbl;
               quo_ff <= {quo_ff[D_FRAC-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(D_FRAC - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule

// ----- hw/rtl/tlik_sqrt.sv -----
// Digit-by-digit integer square root (floor), one result bit per cycle.
// Depends on tlik_pkg.
module tlik_sqrt
   import tlik_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [SQ_W-1:0]  radicand,
   output unit_stat_type    stat,
   output logic [D_FRAC:0]  root
);

   logic             busy_ff;
   logic             done_ff;
   logic [SQ_W-1:0]  val_ff;
   logic [SQ_W:0]    res_ff;
   logic [SQ_W-1:0]  bit_ff;
   logic [SQ_W:0]    trial;

   assign trial = res_ff + {1'b0, bit_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            val_ff  <= radicand;
            res_ff  <= '0;
            bit_ff  <= SQ_W'(1) << (SQ_W - 1);
         end else if (busy_ff) begin
            if ({1'b0, val_ff} >= trial) begin
               val_ff <= val_ff - trial[SQ_W-1:0];
               res_ff <= (res_ff >> 1) + {1'b0, bit_ff};
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
            // The last step is the one with the lowest bit set.
            if (bit_ff[0]) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign root      = res_ff[D_FRAC:0];

endmodule

// ----- hw/rtl/tlik_cordic.sv -----
// Vectoring CORDIC atan2 with operand normalization, one step per cycle.
// Depends on tlik_pkg for the Q60 arctangent table and widths.
module tlik_cordic
   import tlik_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [OPND_W-1:0] y_in,
   input  logic signed [OPND_W-1:0] x_in,
   output unit_stat_type            stat,
   output q60_type                  angle
);

   typedef enum logic [1:0] {C_IDLE, C_NORM, C_QUAD, C_ROT} cstate_type;

   localparam logic [OPND_W-1:0] M_BIG4  = OPND_W'(1) << 45;
   localparam logic [OPND_W-1:0] M_HIGH  = OPND_W'(1) << 42;
   localparam logic [OPND_W-1:0] M_LOW   = OPND_W'(1) << 40;
   localparam logic [OPND_W-1:0] M_TINY8 = OPND_W'(1) << 33;

   cstate_type                state_ff;
   logic                      done_ff;
   logic signed [OPND_W-1:0]  x_ff;
   logic signed [OPND_W-1:0]  y_ff;
   logic [OPND_W-1:0]         m_ff;
   q60_type                   z_ff;
   logic [ITER_W-1:0]         cnt_ff;
   logic [OPND_W-1:0]         ax;
   logic [OPND_W-1:0]         ay;
   logic signed [OPND_W-1:0]  xs;
   logic signed [OPND_W-1:0]  ys;

   assign ax = x_in[OPND_W-1] ? OPND_W'(-x_in) : OPND_W'(x_in);
   assign ay = y_in[OPND_W-1] ? OPND_W'(-y_in) : OPND_W'(y_in);
   assign xs = x_ff >>> cnt_ff;
   assign ys = y_ff >>> cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            C_IDLE: begin
               if (start) begin
                  if (x_in == '0 && y_in == '0) begin
                     z_ff    <= '0;
                     done_ff <= 1'b1;
                  end else begin
                     x_ff     <= x_in;
                     y_ff     <= y_in;
                     m_ff     <= (ax > ay) ? ax : ay;
                     state_ff <= C_NORM;
                  end
               end
            end
            C_NORM: begin
               // Bring the larger magnitude into [2^40, 2^42).
               if (m_ff >= M_BIG4) begin
                  x_ff <= x_ff >>> 4;
                  y_ff <= y_ff >>> 4;
                  m_ff <= m_ff >> 4;
               end else if (m_ff >= M_HIGH) begin
                  x_ff <= x_ff >>> 1;
                  y_ff <= y_ff >>> 1;
                  m_ff <= m_ff >> 1;
               end else if (m_ff < M_TINY8) begin
                  x_ff <= x_ff <<< 8;
                  y_ff <= y_ff <<< 8;
                  m_ff <= m_ff << 8;
               end else if (m_ff < M_LOW) begin
                  x_ff <= x_ff <<< 1;
                  y_ff <= y_ff <<< 1;
                  m_ff <= m_ff << 1;
               end else begin
                  state_ff <= C_QUAD;
               end
            end
            C_QUAD: begin
               // Rotate the left half plane by a quarter turn first.
               if (x_ff < 0) begin
                  if (y_ff >= 0) begin
                     x_ff <= y_ff;
                     y_ff <= -x_ff;
                     z_ff <= HALF_PI_Q60;
                  end else begin
                     x_ff <= -y_ff;
                     y_ff <= x_ff;
                     z_ff <= -HALF_PI_Q60;
                  end
               end else begin
                  z_ff <= '0;
               end
               cnt_ff   <= '0;
               state_ff <= C_ROT;
            end
            C_ROT: begin
               if (y_ff > 0) begin
                  x_ff <= x_ff + ys;
                  y_ff <= y_ff - xs;
                  z_ff <= z_ff + q60_type'(ATAN_TAB[cnt_ff]);
               end else begin
                  x_ff <= x_ff - ys;
                  y_ff <= y_ff + xs;
                  z_ff <= z_ff - q60_type'(ATAN_TAB[cnt_ff]);
               end
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == ITER_W'(CORDIC_ITERATIONS - 1)) begin
                  done_ff  <= 1'b1;
                  state_ff <= C_IDLE;
               end
            end
            default: state_ff <= C_IDLE;
         endcase
      end
   end

   assign stat.busy = (state_ff != C_IDLE);
   assign stat.done = done_ff;
   assign angle     = z_ff;

endmodule

// ----- dv/two_link_arm_inverse_kinematics_top_test.sv -----
// Self-checking testbench for the two-link arm inverse kinematics block.
// Drives target words with random gaps and output stalls, and predicts each joint solution.
// Depends on tlik_pkg and two_link_arm_inverse_kinematics_top.
module two_link_arm_inverse_kinematics_top_test;
   import tlik_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [17:0] x;
      logic signed [17:0] y;
      logic signed [31:0] yaw;
   } target_word_type;

   typedef struct {
      logic signed [31:0] shoulder;
      logic signed [31:0] elbow;
      logic signed [31:0] wrist;
      logic               elbow_pos;
      logic               unreach;
   } joint_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [17:0] req_target_x = '0;
   logic signed [17:0] req_target_y = '0;
   logic signed [31:0] req_tool_yaw = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_shoulder_angle, rsp_elbow_angle, rsp_wrist_angle;
   logic rsp_elbow_positive, rsp_unreachable;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   two_link_arm_inverse_kinematics_top u_dut (.*);

   always #1 clock = ~clock;

   target_word_type pending_targets[$];
   joint_word_type  expected_joints[$];
   logic signed [63:0] link1_len = 256, link2_len = 256;
   logic signed [63:0] prev_shoulder = 0, prev_elbow = 0;
   int  error_count = 0;
   int  cycle_count = 0;
   bit  quiet = 0;
   bit  target_taken = 0, joint_taken = 0;
   int  target_gap = 0, joint_hold = 0;

   function automatic logic signed [63:0] round_angle(input logic signed [63:0] v);
      return (v + (64'sd1 <<< (59 - ANGLE_FRAC_BITS))) >>> (60 - ANGLE_FRAC_BITS);
   endfunction

   function automatic logic signed [63:0] clip32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic logic signed [63:0] abs_diff(input logic signed [63:0] a, b);
      return a > b ? a - b : b - a;
   endfunction

   function automatic logic signed [63:0] nearest_copy(input logic signed [63:0] t, prev,
                                                       input logic signed [63:0] turn);
      logic signed [63:0] up, dn, st;
      up = abs_diff(t + turn, prev);
      dn = abs_diff(t - turn, prev);
      st = abs_diff(t, prev);
      if (up < dn && up < st) return t + turn;
      if (dn < up && dn < st) return t - turn;
      return t;
   endfunction

   function automatic logic [63:0] floor_root(input logic [63:0] v);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // Vectoring rotation: returns atan2(yv, xv) with 60 fraction bits.
   function automatic logic signed [63:0] arc_tangent(input logic signed [63:0] yv, xv);
      logic [63:0] ax, ay, m;
      logic signed [63:0] z, t, nx, ny;
      z = 0;
      if (xv == 0 && yv == 0) return 0;
      ax = xv < 0 ? -xv : xv;
      ay = yv < 0 ? -yv : yv;
      m = ax > ay ? ax : ay;
      while (m >= (64'd1 << 42)) begin
         xv = xv >>> 1;
         yv = yv >>> 1;
         m = m >> 1;
      end
      while (m < (64'd1 << 40)) begin
         xv = xv * 2;
         yv = yv * 2;
         m = m << 1;
      end
      if (xv < 0) begin
         t = xv;
         if (yv >= 0) begin
            xv = yv;
            yv = -t;
            z = PI_Q60 / 2;
         end else begin
            xv = -yv;
            yv = t;
            z = -(PI_Q60 / 2);
         end
      end
      for (int i = 0; i < CORDIC_ITERATIONS && i < 32; i++) begin
         if (yv > 0) begin
            nx = xv + (yv >>> i);
            ny = yv - (xv >>> i);
            z = z + $signed(ATAN_TAB[i]);
         end else begin
            nx = xv - (yv >>> i);
            ny = yv + (xv >>> i);
            z = z - $signed(ATAN_TAB[i]);
         end
         xv = nx;
         yv = ny;
      end
      return z;
   endfunction

   // Solves one target and advances the stored previous angles.
   function automatic joint_word_type solve_joints(input target_word_type w);
      joint_word_type j;
      logic signed [63:0] x, y, pi_a, turn, num, den, d, sn, e60, a60, b60, t1, t2;
      logic [63:0] anum, q, r, s;
      logic pos, neg, unr;
      x = w.x;
      y = w.y;
      pi_a = round_angle(PI_Q60);
      turn = round_angle(PI_Q60 * 2);
      pos = (prev_elbow > 0 && prev_elbow < pi_a) ||
            (prev_elbow > -turn && prev_elbow < -pi_a);
      num = x * x + y * y - link1_len * link1_len - link2_len * link2_len;
      den = 2 * link1_len * link2_len;
      neg = num < 0;
      anum = neg ? -num : num;
      if (den == 0) begin
         q = 64'd1 << 30;
         unr = num != 0;
      end else if (anum >= den) begin
         q = 64'd1 << 30;
         unr = anum > den;
      end else begin
         r = anum;
         q = 0;
         for (int i = 0; i < 30; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
               r = r - den;
               q = q | 64'd1;
            end
         end
         unr = 0;
      end
      d = neg ? -$signed(q) : $signed(q);
      s = floor_root((64'd1 << 60) - q * q);
      e60 = arc_tangent($signed(s), d);
      sn = $signed(s);
      if (!pos) begin
         e60 = -e60;
         sn = -sn;
      end
      b60 = arc_tangent(link2_len * sn, link1_len * (64'sd1 <<< 30) + link2_len * d);
      a60 = arc_tangent(x, y);
      t1 = clip32(nearest_copy(round_angle(a60 - b60), prev_shoulder, turn));
      t2 = clip32(nearest_copy(round_angle(e60), prev_elbow, turn));
      j.wrist = 32'(clip32(64'(w.yaw) - t1 - t2));
      prev_shoulder = t1;
      prev_elbow = t2;
      j.shoulder = 32'(t1);
      j.elbow = 32'(t2);
      j.elbow_pos = pos;
      j.unreach = unr;
      return j;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 3000000) begin
         $display("Simulation FAILED");
         $finish;
      end
      if (!reset && req_valid && !req_stall) begin
         target_word_type w;
         w.x = req_target_x;
         w.y = req_target_y;
         w.yaw = req_tool_yaw;
         expected_joints.push_back(solve_joints(w));
         target_taken = 1;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         joint_word_type e;
         joint_taken = 1;
         if (expected_joints.size() == 0) begin
            $display("%0t: result word with nothing expected, got %h %h %h %b %b", $realtime,
                     rsp_shoulder_angle, rsp_elbow_angle, rsp_wrist_angle,
                     rsp_elbow_positive, rsp_unreachable);
            error_count++;
         end else begin
            e = expected_joints.pop_front();
            if (rsp_shoulder_angle !== e.shoulder) begin
               $display("%0t: shoulder expected %0d got %0d", $realtime, e.shoulder,
                        rsp_shoulder_angle);
               error_count++;
            end
            if (rsp_elbow_angle !== e.elbow) begin
               $display("%0t: elbow expected %0d got %0d", $realtime, e.elbow,
                        rsp_elbow_angle);
               error_count++;
            end
            if (rsp_wrist_angle !== e.wrist) begin
               $display("%0t: wrist expected %0d got %0d", $realtime, e.wrist,
                        rsp_wrist_angle);
               error_count++;
            end
            if (rsp_elbow_positive !== e.elbow_pos) begin
               $display("%0t: elbow_positive expected %b got %b", $realtime, e.elbow_pos,
                        rsp_elbow_positive);
               error_count++;
            end
            if (rsp_unreachable !== e.unreach) begin
               $display("%0t: unreachable expected %b got %b", $realtime, e.unreach,
                        rsp_unreachable);
               error_count++;
            end
         end
      end
   end

   // Input side: a word is held until taken, then a fresh gap is drawn.
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !target_taken) begin
            req_valid <= 1'b1;
         end else if (target_gap > 0) begin
            target_gap <= target_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_targets.size() != 0) begin
            target_word_type w;
            w = pending_targets.pop_front();
            req_target_x <= w.x;
            req_target_y <= w.y;
            req_tool_yaw <= w.yaw;
            req_valid <= 1'b1;
            target_gap <= quiet ? 0 : $urandom_range(0, 5);
         end else begin
            req_valid <= 1'b0;
         end
         target_taken = 0;
         if (joint_taken) begin
            joint_hold = quiet ? 0 : $urandom_range(0, 5);
            joint_taken = 0;
         end
         if (joint_hold > 0) begin
            rsp_stall <= 1'b1;
            joint_hold = joint_hold - 1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic write_link(input logic sel, input logic [15:0] len);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {sel, 2'b00};
      pwdata <= {16'h0, len};
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (sel == REG_FIRST_LINK) link1_len = len;
      else link2_len = len;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic queue_target(input logic signed [17:0] x, y, input logic signed [31:0] yaw);
      target_word_type w;
      w.x = x;
      w.y = y;
      w.yaw = yaw;
      pending_targets.push_back(w);
   endtask

   task automatic drain_words();
      while (pending_targets.size() != 0 || expected_joints.size() != 0 || req_valid)
         @(posedge clock);
      repeat (250) @(posedge clock);
   endtask

   // Mostly targets around the arm's reach, some anywhere, some near the base.
   task automatic queue_random(input int count);
      int reach, kind;
      logic signed [17:0] x, y;
      reach = int'(link1_len + link2_len) + 16;
      if (reach > 131071) reach = 131071;
      for (int i = 0; i < count; i++) begin
         kind = $urandom_range(0, 9);
         if (kind < 6) begin
            x = 18'($urandom_range(0, 2 * reach) - reach);
            y = 18'($urandom_range(0, 2 * reach) - reach);
         end else if (kind < 8) begin
            x = 18'($urandom);
            y = 18'($urandom);
         end else begin
            x = 18'($urandom_range(0, 64) - 32);
            y = 18'($urandom_range(0, 64) - 32);
         end
         queue_target(x, y, $urandom);
         if ($urandom_range(0, 49) == 0) quiet = ~quiet;
      end
   endtask

   initial begin
      logic [15:0] l1, l2;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // Directed words at the reset lengths: base, full reach, extremes, yaw limits.
      queue_target(0, 0, 0);
      queue_target(18'sd512, 0, 0);
      queue_target(0, 18'sd512, 32'sd2147483647);
      queue_target(-18'sd512, 0, -32'sd2147483648);
      queue_target(0, -18'sd513, 0);
      queue_target(18'sd131071, 18'sd131071, 32'sd2147483647);
      queue_target(-18'sd131072, -18'sd131072, -32'sd2147483648);
      queue_target(-18'sd131072, 18'sd131071, 32'sd1);
      queue_target(18'sd300, 18'sd100, 32'sd1647099);
      queue_target(-18'sd1, 0, -32'sd1);
      queue_target(18'sd1, 18'sd1, 32'sd3294199);
      queue_target(18'sd200, -18'sd200, -32'sd3294199);
      queue_target(0, 0, 32'sd2147483647);
      queue_target(-18'sd362, -18'sd362, 0);
      queue_target(18'sd10, -18'sd400, 0);
      drain_words();
      write_link(REG_FIRST_LINK, 16'd65535);
      write_link(REG_SECOND_LINK, 16'd1);
      queue_target(0, 0, 0);
      queue_target(18'sd131071, 0, 0);
      queue_target(-18'sd131072, 18'sd131071, 32'sd2147483647);
      queue_random(300);
      drain_words();
      write_link(REG_FIRST_LINK, 16'd1);
      write_link(REG_SECOND_LINK, 16'd1);
      queue_target(18'sd2, 0, 0);
      queue_target(0, 0, 0);
      queue_random(300);
      drain_words();
      write_link(REG_SECOND_LINK, 16'd65535);
      queue_random(300);
      drain_words();
      write_link(REG_FIRST_LINK, 16'd256);
      write_link(REG_SECOND_LINK, 16'd256);
      queue_random(400);
      for (int p = 0; p < 4; p++) begin
         drain_words();
         l1 = (p == 0) ? 16'd65535 : 16'($urandom_range(1, 40000));
         l2 = (p == 0) ? 16'd65535 : 16'($urandom_range(1, 40000));
         write_link(REG_FIRST_LINK, l1);
         write_link(REG_SECOND_LINK, l2);
         queue_random(150);
      end
      drain_words();
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/tlik_pkg.sv
hw/rtl/tlik_divider.sv
hw/rtl/tlik_sqrt.sv
hw/rtl/tlik_cordic.sv
hw/rtl/two_link_arm_inverse_kinematics_top.sv
dv/two_link_arm_inverse_kinematics_top_test.sv
